// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/gmm_pkg.sv =====
package gmm_pkg;
  localparam int RATE_FRAC_BITS_DEF = 4;
  localparam int LOG_TABLE_ENTRIES_DEF = 32;
  localparam logic [31:0] DRAG_MS = 32'd400;
  localparam logic [31:0] CLICK_MS = 32'd80;
  localparam logic [31:0] SPACING_MS = 32'd250;
  localparam int SCROLL_DIV = 20;
  localparam logic [1:0] GEST_CLOSE = 2'd1;
  localparam logic [1:0] GEST_OPEN = 2'd2;
  localparam logic [2:0] REG_CLUTCH_LOW = 3'd0;
  localparam logic [2:0] REG_CLUTCH_HIGH = 3'd1;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd2;
  localparam logic [2:0] REG_ACCEL = 3'd3;
  localparam logic [2:0] REG_GAIN = 3'd4;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [9:0]  accel;
    logic [15:0] gain;
  } shape_cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (b > v) b = b >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] log_entry(input int i, input int n);
    logic [63:0] x;
    logic [31:0] res;
    x = (64'd1 << 30) + ((64'(i) << 30) / 64'(n));
    res = 32'd0;
    if (i >= n) return 32'd65536;
    for (int j = 1; j <= 16; j++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        res = res | (32'd1 << (16 - j));
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] exp_entry(input int i, input int n);
    logic [63:0] root [17];
    logic [63:0] acc, f16;
    root[0] = 64'd1 << 31;
    acc = 64'd1 << 30;
    f16 = (64'(i) << 16) / 64'(n);
    if (i >= n) return 32'd131072;
    for (int j = 1; j <= 16; j++) root[j] = isqrt64(root[j-1] << 30);
    for (int j = 1; j <= 16; j++) begin
      if (f16[16-j]) acc = (acc * root[j]) >> 30;
    end
    return 32'(acc >> 14);
  endfunction
endpackage

// ===== sv/gmm_lane.sv =====
// One shaping lane: |r|^accel * gain via log2/exp2, a step per cycle
module gmm_lane #(
  parameter int RATE_FRAC_BITS = gmm_pkg::RATE_FRAC_BITS_DEF,
  parameter int LOG_TABLE_ENTRIES = gmm_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  rate,
  input  gmm_pkg::shape_cfg_t cfg,
  output logic                done,
  output logic signed [7:0]   result
);
  localparam int IW = $clog2(LOG_TABLE_ENTRIES);
  localparam int NB = IW + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_LOG = 3'd1, S_MUL = 3'd2, S_EXP = 3'd3,
                         S_GAIN = 3'd4, S_OUT = 3'd5;

  typedef logic [LOG_TABLE_ENTRIES:0][31:0] tab_t;

  // tables are fixed at elaboration
  function automatic tab_t build_tab(input logic is_log);
    tab_t t;
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      t[i] = is_log ? gmm_pkg::log_entry(i, LOG_TABLE_ENTRIES)
                    : gmm_pkg::exp_entry(i, LOG_TABLE_ENTRIES);
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_tab(1'b1);
  localparam tab_t EXP_TAB = build_tab(1'b0);

  logic [2:0] state;
  logic neg, zero;
  logic [16:0] m;
  logic signed [21:0] lg;
  logic signed [32:0] p;
  logic [17:0] ef;

  logic [4:0] k_c;
  logic [31:0] u_c;
  logic [15:0] q_c;
  logic [NB+15:0] t_c;
  logic [NB-1:0] ti_c;
  logic [15:0] rm_c;
  logic [31:0] lo_c, hi_c, ip_c;
  logic [15:0] fr_c;
  logic [47:0] mag_c;
  logic signed [16:0] n_c;
  logic signed [17:0] sh_c;
  logic [7:0] mag8_c;

  always_comb begin
    k_c = 5'd0;
    for (int b = 1; b < 17; b++) if (m[b]) k_c = 5'(b);
    u_c = (32'(m) << 16) >> k_c;
    fr_c = p[15:0];
    q_c = (state == S_LOG) ? u_c[15:0] : fr_c;
    t_c = (NB+16)'(q_c) * (NB+16)'(LOG_TABLE_ENTRIES);
    ti_c = t_c[NB+15:16];
    rm_c = t_c[15:0];
    lo_c = (state == S_LOG) ? LOG_TAB[ti_c] : EXP_TAB[ti_c];
    hi_c = (state == S_LOG) ? LOG_TAB[ti_c + NB'(1)] : EXP_TAB[ti_c + NB'(1)];
    ip_c = lo_c + 32'((48'(hi_c - lo_c) * 48'(rm_c)) >> 16);
    mag_c = 48'(ef) * 48'(cfg.gain);
    n_c = p[32:16];
    sh_c = 18'(n_c) - 18'sd24;
    if (sh_c >= 0) begin
      if (mag_c != 48'd0 && sh_c >= 8) mag8_c = 8'd128;
      else mag8_c = ((mag_c << sh_c[2:0]) > 48'd128) ? 8'd128 : 8'(mag_c << sh_c[2:0]);
    end else if (-sh_c >= 18'sd48) begin
      mag8_c = 8'd0;
    end else begin
      mag8_c = ((mag_c >> (-sh_c)) > 48'd128) ? 8'd128 : 8'(mag_c >> (-sh_c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          neg <= rate[15];
          m <= rate[15] ? 17'(-18'(rate)) : 17'(rate);
          zero <= (rate == 16'sd0) ||
                  ((rate[15] ? 17'(-18'(rate)) : 17'(rate)) < 17'(cfg.dead_zone));
          state <= S_LOG;
        end
        S_LOG: begin
          lg <= 22'(($signed({1'b0, k_c}) - 6'sd0 - RATE_FRAC_BITS) * 65536) +
                22'(ip_c);
          state <= S_MUL;
        end
        S_MUL: begin
          p <= 33'((34'(lg) * $signed({1'b0, cfg.accel})) >>> 8);
          state <= S_EXP;
        end
        S_EXP: begin
          ef <= 18'(ip_c);
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (zero) result <= 8'sd0;
          else if (neg) result <= 8'(-9'(mag8_c));
          else result <= (mag8_c > 8'd127) ? 8'sd127 : mag8_c;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/gmm_gesture.sv =====
`include "assert_macros.svh"
// Gesture timing: clicks, drag, scroll; merges lane results into a report
module gmm_gesture #(
  parameter int RATE_FRAC_BITS = gmm_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [31:0]        time_ms,
  input  logic [1:0]         intent,
  input  logic signed [15:0] pitch_rate,
  input  logic               freeze,
  input  logic [14:0]        dead_zone,
  input  logic signed [7:0]  dx,
  input  logic signed [7:0]  dy,
  output logic signed [7:0]  move_x,
  output logic signed [7:0]  move_y,
  output logic signed [7:0]  scroll_step,
  output logic               left_button,
  output logic               right_button
);
  // |py| / (20 << frac): shift out 4 << frac, then divide by 5 as *13108 >> 16,
  // exact while the shifted value stays below 16384
  localparam int SC_SHIFT = RATE_FRAC_BITS + 2;
  localparam logic [14:0] RECIP5 = 15'd13108;

  logic [31:0] close_start, open_start, last_click_time;
  logic drag_active, close_held, open_held;

  logic [31:0] cd_c, od_c;
  logic [16:0] ap_c;
  logic signed [16:0] py_c, w_c;
  logic [16:0] sc_b_c, sc_q_c;
  logic [31:0] sc_p_c;
  logic drag_n, lclick, rclick, scroll;

  always_comb begin
    ap_c = pitch_rate[15] ? 17'(-18'(pitch_rate)) : 17'(pitch_rate);
    py_c = (ap_c < 17'(dead_zone)) ? 17'sd0 : 17'(pitch_rate);
    sc_b_c = (py_c == 17'sd0) ? 17'd0 : (ap_c >> SC_SHIFT);
    sc_p_c = 32'(sc_b_c) * 32'(RECIP5);
    sc_q_c = 17'(sc_p_c >> 16);
    w_c = py_c[16] ? $signed(sc_q_c) : -$signed(sc_q_c);
    cd_c = close_held ? time_ms - close_start : 32'd0;
    od_c = open_held ? time_ms - open_start : 32'd0;
    lclick = intent != gmm_pkg::GEST_CLOSE && close_held && !drag_active &&
             cd_c >= gmm_pkg::CLICK_MS && time_ms - last_click_time >= gmm_pkg::SPACING_MS;
    rclick = intent != gmm_pkg::GEST_OPEN && open_held && od_c >= gmm_pkg::CLICK_MS &&
             od_c < gmm_pkg::DRAG_MS &&
             (lclick || time_ms - last_click_time >= gmm_pkg::SPACING_MS);
    if (lclick) rclick = 1'b0;
    drag_n = intent == gmm_pkg::GEST_CLOSE && (drag_active || cd_c >= gmm_pkg::DRAG_MS);
    scroll = intent == gmm_pkg::GEST_OPEN && od_c >= gmm_pkg::DRAG_MS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      close_held <= 1'b0;
      open_held <= 1'b0;
      drag_active <= 1'b0;
      last_click_time <= 32'd0;
      close_start <= 32'd0;
      open_start <= 32'd0;
    end else if (step) begin
      if (intent == gmm_pkg::GEST_CLOSE) begin
        if (!close_held) close_start <= time_ms;
        close_held <= 1'b1;
      end else close_held <= 1'b0;
      drag_active <= drag_n;
      if (intent == gmm_pkg::GEST_OPEN) begin
        if (!open_held) open_start <= time_ms;
        open_held <= 1'b1;
      end else open_held <= 1'b0;
      if (lclick || rclick) last_click_time <= time_ms;
      move_x <= freeze ? 8'sd0 : dx;
      move_y <= (freeze || scroll) ? 8'sd0 : dy;
      scroll_step <= !scroll ? 8'sd0 : (w_c > 17'sd127) ? 8'sd127 :
                     (w_c < -17'sd128) ? -8'sd128 : 8'(w_c);
      left_button <= lclick || drag_n;
      right_button <= rclick;
    end
  end

  `ASSERT_CLK(a_drag_needs_close, drag_active |-> close_held, "drag without close")
  `ASSERT_CLK(a_one_click, step |=> !(left_button && right_button && !drag_active),
    "left and right click together")
  `ASSERT_CLK_RST(a_rst_idle, rst |=> !close_held && !open_held, "held after reset")
endmodule

// ===== sv/gesture_mouse_mapper_unit.sv =====
// Gesture mouse mapper.
// Input channel: in_valid/in_stall with time_ms, intent, flex_effort, yaw_rate,
// pitch_rate, imu_valid. Output channel: out_valid/out_stall with move_x,
// move_y, scroll_step, left_button, right_button. One report per tick.
// Config: cfg_we/cfg_index/cfg_data, 0 clutch_low .. 4 motion_gain.
// Yaw and pitch are shaped by two lanes in parallel; each lane runs log2,
// multiply, exp2 and gain as a five-step sequence, then a merge stage applies
// clutch, gesture timing and scroll. One tick is in flight at a time; a new
// tick is taken once the previous one has passed the merge stage. The
// finished report sits in the output register; the next tick is accepted
// while it waits but its result is held back until the previous report is
// taken (out_stall low).
// Reset (synchronous, rst high) restores register defaults and drops held
// gestures, drag and the last-click time; no report is pending after it.
`include "assert_macros.svh"
module gesture_mouse_mapper_unit #(
  parameter int RATE_FRAC_BITS = gmm_pkg::RATE_FRAC_BITS_DEF,
  parameter int LOG_TABLE_ENTRIES = gmm_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        time_ms,
  input  logic [1:0]         intent,
  input  logic [15:0]        flex_effort,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [15:0] pitch_rate,
  input  logic               imu_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  move_x,
  output logic signed [7:0]  move_y,
  output logic signed [7:0]  scroll_step,
  output logic               left_button,
  output logic               right_button,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic [15:0] clutch_low, clutch_high;
  gmm_pkg::shape_cfg_t scfg;
  logic busy, done_x, done_y, merge_wait;
  logic [31:0] t_r;
  logic [1:0] int_r;
  logic [15:0] flex_r;
  logic signed [15:0] pitch_r;
  logic imu_r;
  logic signed [7:0] dx, dy;
  logic step, freeze, in_acc;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = busy;
  assign step = done_x && (!out_valid || !out_stall);
  assign freeze = (flex_r > clutch_low && flex_r < clutch_high) || !imu_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      clutch_low <= 16'd200;
      clutch_high <= 16'd800;
      scfg.dead_zone <= 15'd48;
      scfg.accel <= 10'd384;
      scfg.gain <= 16'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmm_pkg::REG_CLUTCH_LOW: clutch_low <= cfg_data;
        gmm_pkg::REG_CLUTCH_HIGH: clutch_high <= cfg_data;
        gmm_pkg::REG_DEAD_ZONE: scfg.dead_zone <= cfg_data[14:0];
        gmm_pkg::REG_ACCEL: scfg.accel <= cfg_data[9:0];
        gmm_pkg::REG_GAIN: scfg.gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // the x lane's done pulse is held until the merge stage can fire (lanes run in lockstep)
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      merge_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
        t_r <= time_ms;
        int_r <= intent;
        flex_r <= flex_effort;
        pitch_r <= pitch_rate;
        imu_r <= imu_valid;
      end
      if (done_x && !step) merge_wait <= 1'b1;
      if (step) begin
        merge_wait <= 1'b0;
        busy <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  logic lane_done_x;
  assign done_x = lane_done_x || merge_wait;

  gmm_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS), .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_lx (
    .clk(clk), .rst(rst), .start(in_acc), .rate(yaw_rate), .cfg(scfg),
    .done(lane_done_x), .result(dx));
  gmm_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS), .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_ly (
    .clk(clk), .rst(rst), .start(in_acc), .rate(pitch_rate), .cfg(scfg),
    .done(done_y), .result(dy));

  gmm_gesture #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_gest (
    .clk(clk), .rst(rst), .step(step), .time_ms(t_r), .intent(int_r),
    .pitch_rate(pitch_r), .freeze(freeze), .dead_zone(scfg.dead_zone),
    .dx(dx), .dy(dy), .move_x(move_x), .move_y(move_y), .scroll_step(scroll_step),
    .left_button(left_button), .right_button(right_button));

  `ASSERT_CLK(a_lanes_lockstep, lane_done_x == done_y, "lanes out of step")
  `ASSERT_CLK(a_no_accept_busy, busy |-> !in_acc, "tick accepted while busy")
  `ASSERT_CLK(a_step_frees, step |=> !busy, "busy after merge")
endmodule

// ===== test/gesture_mouse_mapper_unit_tb.sv =====
module gesture_mouse_mapper_unit_tb;
  localparam logic [1:0] GEST_REST = 2'd0;
  localparam logic [1:0] GEST_OTHER = 2'd3;
  localparam int FRAC = gmm_pkg::RATE_FRAC_BITS_DEF;
  localparam int NTAB = gmm_pkg::LOG_TABLE_ENTRIES_DEF;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [1:0]         intent;
    logic [15:0]        flex;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic               imu;
  } tick_t;

  typedef struct packed {
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [7:0] wheel;
    logic              left;
    logic              right;
  } report_t;

  class mouse_report_board;
    logic [31:0] log2_tab [NTAB+1];
    logic [31:0] exp2_tab [NTAB+1];
    logic [15:0] clutch_lo, clutch_hi, gain;
    logic [14:0] dz;
    logic [9:0]  accel;
    logic [31:0] close_t0, open_t0, prev_click_ms;
    bit          dragging, close_on, open_on;
    report_t     pending_reports[$];
    int          mismatches;

    function new();
      logic [63:0] root [17];
      logic [63:0] x, acc, f16;
      logic [31:0] res;
      root[0] = 64'd1 << 31;
      for (int j = 1; j <= 16; j++) root[j] = int_sqrt(root[j-1] << 30);
      for (int i = 0; i < NTAB; i++) begin
        x = (64'd1 << 30) + ((64'(i) << 30) / NTAB);
        res = 0;
        for (int j = 1; j <= 16; j++) begin
          x = (x * x) >> 30;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            res[16-j] = 1'b1;
          end
        end
        log2_tab[i] = res;
        f16 = (64'(i) << 16) / NTAB;
        acc = 64'd1 << 30;
        for (int j = 1; j <= 16; j++) if (f16[16-j]) acc = (acc * root[j]) >> 30;
        exp2_tab[i] = 32'(acc >> 14);
      end
      log2_tab[NTAB] = 32'd65536;
      exp2_tab[NTAB] = 32'd131072;
      clutch_lo = 200; clutch_hi = 800; dz = 48; accel = 384; gain = 64;
      close_t0 = 0; open_t0 = 0; prev_click_ms = 0;
      dragging = 0; close_on = 0; open_on = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        gmm_pkg::REG_CLUTCH_LOW: clutch_lo = val;
        gmm_pkg::REG_CLUTCH_HIGH: clutch_hi = val;
        gmm_pkg::REG_DEAD_ZONE: dz = val[14:0];
        gmm_pkg::REG_ACCEL: accel = val[9:0];
        gmm_pkg::REG_GAIN: gain = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] lookup(bit use_log, logic [15:0] frac);
      logic [31:0] t, i, lo, hi;
      logic [63:0] rm;
      t = 32'(frac) * NTAB;
      i = t >> 16;
      rm = 64'(t[15:0]);
      if (i >= NTAB) return use_log ? log2_tab[NTAB] : exp2_tab[NTAB];
      lo = use_log ? log2_tab[i] : exp2_tab[i];
      hi = use_log ? log2_tab[i+1] : exp2_tab[i+1];
      return lo + 32'((64'(hi - lo) * rm) >> 16);
    endfunction

    // power curve: sign * |r|^accel * gain, zero inside the dead zone, saturated to int8
    function int shape_rate(logic signed [15:0] r);
      int m, k, sh;
      logic [63:0] u, mag;
      longint lg, p, n;
      logic [31:0] ef;
      m = (r < 0) ? -int'(r) : int'(r);
      if (m == 0 || m < int'(dz)) return 0;
      k = 0;
      while (k < 31 && (m >> (k + 1)) != 0) k++;
      u = (64'(m) << 16) >> k;
      lg = longint'(k - FRAC) * 65536 + longint'(lookup(1, 16'(u - 65536)));
      p = (lg * longint'(accel)) >>> 8;
      n = p >>> 16;
      ef = lookup(0, 16'(p - n * 65536));
      mag = 64'(ef) * 64'(gain);
      sh = int'(n) - 24;
      if (sh >= 0) begin
        if (mag != 0 && sh >= 8) mag = 128;
        else mag = mag << sh;
      end else begin
        mag = (-sh >= 40) ? 64'd0 : (mag >> (-sh));
      end
      if (mag > 128) mag = 128;
      if (r < 0) return -int'(mag);
      return (mag > 127) ? 127 : int'(mag);
    endfunction

    function void note_input(tick_t tk);
      report_t rp;
      int dx, dy, py, wheel, ap;
      bit clutch;
      logic [31:0] d;
      clutch = tk.flex > clutch_lo && tk.flex < clutch_hi;
      ap = (tk.pitch < 0) ? -int'(tk.pitch) : int'(tk.pitch);
      py = (ap < int'(dz)) ? 0 : int'(tk.pitch);
      dx = shape_rate(tk.yaw);
      dy = shape_rate(tk.pitch);
      wheel = 0;
      rp.left = 0;
      rp.right = 0;
      if (clutch || !tk.imu) begin
        dx = 0;
        dy = 0;
      end
      if (tk.intent == gmm_pkg::GEST_CLOSE) begin
        if (!close_on) begin
          close_on = 1;
          close_t0 = tk.time_ms;
        end
        if (tk.time_ms - close_t0 >= gmm_pkg::DRAG_MS) dragging = 1;
      end else if (close_on) begin
        d = tk.time_ms - close_t0;
        if (!dragging && d >= gmm_pkg::CLICK_MS &&
            tk.time_ms - prev_click_ms >= gmm_pkg::SPACING_MS) begin
          rp.left = 1;
          prev_click_ms = tk.time_ms;
        end
        dragging = 0;
        close_on = 0;
        close_t0 = 0;
      end
      if (dragging) rp.left = 1;
      if (tk.intent == gmm_pkg::GEST_OPEN) begin
        if (!open_on) begin
          open_on = 1;
          open_t0 = tk.time_ms;
        end
        if (tk.time_ms - open_t0 >= gmm_pkg::DRAG_MS) begin
          wheel = (-py) / (gmm_pkg::SCROLL_DIV << FRAC);
          if (wheel > 127) wheel = 127;
          if (wheel < -128) wheel = -128;
          dy = 0;
        end
      end else if (open_on) begin
        d = tk.time_ms - open_t0;
        if (d >= gmm_pkg::CLICK_MS && d < gmm_pkg::DRAG_MS &&
            tk.time_ms - prev_click_ms >= gmm_pkg::SPACING_MS) begin
          rp.right = 1;
          prev_click_ms = tk.time_ms;
        end
        open_on = 0;
        open_t0 = 0;
      end
      rp.mx = 8'(dx);
      rp.my = 8'(dy);
      rp.wheel = 8'(wheel);
      pending_reports.push_back(rp);
    endfunction

    function void check(report_t got);
      report_t exp_rp;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
        return;
      end
      exp_rp = pending_reports.pop_front();
      if (got !== exp_rp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: expected %p, got %p", exp_rp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] time_ms = 0;
  logic [1:0] intent = 0;
  logic [15:0] flex_effort = 0;
  logic signed [15:0] yaw_rate = 0;
  logic signed [15:0] pitch_rate = 0;
  logic imu_valid = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [7:0] move_x, move_y, scroll_step;
  logic left_button, right_button;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  mouse_report_board board = new();
  int idle_cycles = 0;
  bit took_any;
  int burst_left = 0;
  logic [31:0] clock_ms = 0;
  logic [15:0] cur_flex;

  gesture_mouse_mapper_unit dut (.*);

  always #1 clk = ~clk;

  // receiver stall pattern: changes mode now and then
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    took_any = 0;
    if (!rst && out_valid && !out_stall) begin
      board.check('{move_x, move_y, scroll_step, left_button, right_button});
      took_any = 1;
    end
    if (!rst && in_valid && !in_stall) took_any = 1;
    if (rst || took_any || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_tick(tick_t tk);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1;
    time_ms <= tk.time_ms;
    intent <= tk.intent;
    flex_effort <= tk.flex;
    yaw_rate <= tk.yaw;
    pitch_rate <= tk.pitch;
    imu_valid <= tk.imu;
    do @(posedge clk); while (in_stall);
    board.note_input(tk);
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] dz,
                            logic [15:0] acc, logic [15:0] gn);
    logic [15:0] vals [5];
    logic [2:0] idx [5];
    vals = '{lo, hi, dz, acc, gn};
    idx = '{gmm_pkg::REG_CLUTCH_LOW, gmm_pkg::REG_CLUTCH_HIGH, gmm_pkg::REG_DEAD_ZONE,
            gmm_pkg::REG_ACCEL, gmm_pkg::REG_GAIN};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      board.set_reg(idx[i], vals[i]);
    end
    cfg_we <= 0;
  endtask

  function automatic logic signed [15:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(0, 120)) - 60);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'(int'($urandom_range(0, 1000)) - 500);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tick_t make_tick(logic [1:0] it, logic [31:0] t);
    tick_t tk;
    tk.time_ms = t;
    tk.intent = it;
    if ($urandom_range(0, 9) == 0) tk.flex = 16'($urandom);
    else tk.flex = cur_flex;
    tk.yaw = pick_rate();
    tk.pitch = pick_rate();
    tk.imu = ($urandom_range(0, 9) != 0);
    return tk;
  endfunction

  // gesture holds of random length with random content
  task automatic run_gestures(int n);
    logic [1:0] it;
    int hold;
    while (n > 0) begin
      case ($urandom_range(0, 6))
        0, 1: it = gmm_pkg::GEST_CLOSE;
        2, 3: it = gmm_pkg::GEST_OPEN;
        4: it = GEST_OTHER;
        default: it = GEST_REST;
      endcase
      if ($urandom_range(0, 3) == 0) cur_flex = 16'($urandom_range(0, 1200));
      hold = $urandom_range(1, 25);
      for (int h = 0; h < hold && n > 0; h++) begin
        if ($urandom_range(0, 40) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(1, 45);
        if ($urandom_range(0, 30) == 0) it = 2'($urandom);
        send_tick(make_tick(it, clock_ms));
        n--;
      end
    end
  endtask

  task automatic directed_tick(logic [1:0] it, logic [31:0] t, logic [15:0] fx,
                               logic signed [15:0] y, logic signed [15:0] p, logic v);
    tick_t tk;
    tk = '{t, it, fx, y, p, v};
    send_tick(tk);
  endtask

  initial begin
    cur_flex = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // edge rates, dead zone borders, freeze conditions
    directed_tick(GEST_REST, 10, 0, 16'sh7fff, 16'sh8000, 1);
    directed_tick(GEST_REST, 20, 16'hffff, 0, 0, 1);
    directed_tick(GEST_REST, 30, 0, 47, -47, 1);
    directed_tick(GEST_REST, 40, 0, 48, -48, 1);
    directed_tick(GEST_REST, 50, 500, 4000, -4000, 1);
    directed_tick(GEST_OTHER, 60, 0, 4000, -4000, 0);
    // left click, then drag
    directed_tick(gmm_pkg::GEST_CLOSE, 1000, 0, 100, 100, 1);
    directed_tick(gmm_pkg::GEST_CLOSE, 1100, 0, 100, 100, 1);
    directed_tick(GEST_REST, 1200, 0, 100, 100, 1);
    directed_tick(gmm_pkg::GEST_CLOSE, 1300, 0, 0, 0, 1);
    directed_tick(gmm_pkg::GEST_CLOSE, 1700, 0, 0, 0, 1);
    directed_tick(gmm_pkg::GEST_CLOSE, 1800, 0, 0, 0, 1);
    directed_tick(GEST_OTHER, 1810, 0, 0, 0, 1);
    // right click, then scroll both ways
    directed_tick(gmm_pkg::GEST_OPEN, 2000, 0, 0, 0, 1);
    directed_tick(gmm_pkg::GEST_OPEN, 2150, 0, 0, 0, 1);
    directed_tick(GEST_REST, 2200, 0, 0, 0, 1);
    directed_tick(gmm_pkg::GEST_OPEN, 3000, 0, 0, 0, 1);
    directed_tick(gmm_pkg::GEST_OPEN, 3400, 0, 0, 16'sh8000, 1);
    directed_tick(gmm_pkg::GEST_OPEN, 3410, 0, 0, 16'sh7fff, 0);
    directed_tick(gmm_pkg::GEST_OPEN, 3420, 0, 0, -320, 1);
    directed_tick(GEST_REST, 3430, 0, 0, 0, 1);
    // close across the time wrap
    directed_tick(gmm_pkg::GEST_CLOSE, 32'hffff_ffc0, 0, 0, 0, 1);
    directed_tick(GEST_REST, 32'h0000_0060, 0, 0, 0, 1);
    clock_ms = 32'h0000_1000;
    run_gestures(150);
    write_regs(16'd0, 16'hffff, 16'd0, 16'd0, 16'd0);
    run_gestures(110);
    write_regs(16'hffff, 16'd0, 16'h7fff, 16'h3ff, 16'hffff);
    run_gestures(90);
    write_regs(16'd5, 16'd6, 16'd0, 16'h3ff, 16'd256);
    run_gestures(110);
    write_regs(16'd100, 16'hffff, 16'd16, 16'd256, 16'hffff);
    clock_ms = 32'hffff_f000;
    run_gestures(120);
    for (int ph = 0; ph < 3; ph++) begin
      write_regs(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 200)), 16'($urandom_range(0, 1023)),
                 16'($urandom));
      run_gestures(105);
    end
    write_regs(16'd200, 16'd800, 16'd48, 16'd384, 16'd64);
    clock_ms = $urandom;
    run_gestures(40);
    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/gmm_pkg.sv
sv/gmm_lane.sv
sv/gmm_gesture.sv
sv/gesture_mouse_mapper_unit.sv
test/gesture_mouse_mapper_unit_tb.sv
